/* hdl/cltm_pkg.sv */
`timescale 1ns / 1ps
// Package for the CPU list text to mask core: character codes, phase and
// walker state types, and the command flags that pass from parser to walker.
// No dependencies.
package cltm_pkg;

   localparam int unsigned MASK_W      = 64;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   typedef enum logic [2:0] {
      PH_START,
      PH_NUM_A,
      PH_WANT_B,
      PH_NUM_B,
      PH_WANT_S,
      PH_NUM_S
   } phase_type;

   typedef enum logic [1:0] {
      WK_IDLE,
      WK_WALK,
      WK_SEND
   } walk_state_type;

   // One queued command: close a token, end the text, or both.
   typedef struct packed {
      logic last;
      logic close;
      logic fail;
   } cmd_flags_type;

   localparam int unsigned CMD_FLAGS_W = $bits(cmd_flags_type);

endpackage

/* hdl/cltm_front.sv */
`timescale 1ns / 1ps
// Front parser: takes one text word per accepted cycle, tracks token phase
// and numbers, emits close-token and end-of-text commands. Depends on cltm_pkg.
module cltm_front #(
   parameter int unsigned NUMBER_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [7:0]                req_character,
   input  logic                      req_end_of_text,
   output logic                      cmd_push,
   output cltm_pkg::cmd_flags_type   cmd_flags,
   output logic [NUMBER_BITS-1:0]    cmd_start,
   output logic [NUMBER_BITS-1:0]    cmd_end,
   output logic [NUMBER_BITS-1:0]    cmd_step
);
   import cltm_pkg::*;

   localparam int unsigned AW = NUMBER_BITS + 4;

   phase_type               phase_ff, phase_in;
   logic [NUMBER_BITS-1:0]  start_ff, start_in;
   logic [NUMBER_BITS-1:0]  end_ff, end_in;
   logic [NUMBER_BITS-1:0]  step_ff, step_in;
   logic                    junk_ff, junk_in;
   logic                    fail_ff, fail_in;

   logic                    is_digit, is_comma, in_number;
   logic [7:0]              digit_code;
   logic [NUMBER_BITS-1:0]  cur_num;
   logic [AW-1:0]           cur_ext, acc;
   logic                    acc_ovf;
   logic [NUMBER_BITS-1:0]  acc_val;

   assign is_digit   = (req_character >= CHAR_ZERO) && (req_character <= CHAR_NINE);
   assign is_comma   = (req_character == CHAR_COMMA);
   assign digit_code = req_character - CHAR_ZERO;
   assign in_number  = (phase_ff == PH_NUM_A) || (phase_ff == PH_NUM_B) ||
                       (phase_ff == PH_NUM_S);

   // times ten plus digit, by shifts
   always_comb begin
      unique case (phase_ff)
         PH_NUM_A: cur_num = start_ff;
         PH_NUM_B: cur_num = end_ff;
         default:  cur_num = step_ff;
      endcase
      cur_ext = AW'(cur_num);
      acc     = (cur_ext << 3) + (cur_ext << 1) + AW'(digit_code[3:0]);
      acc_ovf = |acc[AW-1:NUMBER_BITS];
      acc_val = acc_ovf ? '0 : acc[NUMBER_BITS-1:0];
   end

   // next state and number registers
   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      end_in   = end_ff;
      step_in  = step_ff;
      junk_in  = junk_ff;
      fail_in  = fail_ff;
      if (accept) begin
         if (req_end_of_text || (!fail_ff && in_number && is_comma)) begin
            phase_in = PH_START;
            start_in = '0;
            end_in   = '0;
            step_in  = NUMBER_BITS'(1);
            junk_in  = 1'b0;
            if (req_end_of_text) begin
               fail_in = 1'b0;
            end
         end else if (!fail_ff) begin
            unique case (phase_ff)
               PH_START: begin
                  if (is_digit) begin
                     start_in = NUMBER_BITS'(digit_code[3:0]);
                     phase_in = PH_NUM_A;
                  end else begin
                     fail_in = 1'b1;
                  end
               end
               PH_WANT_B: begin
                  if (is_digit) begin
                     end_in   = NUMBER_BITS'(digit_code[3:0]);
                     junk_in  = 1'b0;
                     phase_in = PH_NUM_B;
                  end else begin
                     fail_in = 1'b1;
                  end
               end
               PH_WANT_S: begin
                  if (is_digit) begin
                     step_in  = NUMBER_BITS'(digit_code[3:0]);
                     junk_in  = 1'b0;
                     phase_in = PH_NUM_S;
                  end else begin
                     fail_in = 1'b1;
                  end
               end
               default: begin
                  priority if (is_digit && !junk_ff) begin
                     if (acc_ovf) begin
                        fail_in = 1'b1;
                     end
                     if (phase_ff == PH_NUM_A) begin
                        start_in = acc_val;
                     end else if (phase_ff == PH_NUM_B) begin
                        end_in = acc_val;
                     end else begin
                        step_in = acc_val;
                     end
                  end else if (phase_ff == PH_NUM_A && req_character == CHAR_DASH) begin
                     phase_in = PH_WANT_B;
                  end else if (phase_ff == PH_NUM_B && req_character == CHAR_COLON) begin
                     phase_in = PH_WANT_S;
                  end else begin
                     junk_in = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // command outputs
   always_comb begin
      cmd_push        = accept && (req_end_of_text || (!fail_ff && in_number && is_comma));
      cmd_flags.last  = req_end_of_text;
      cmd_flags.close = !fail_ff && in_number;
      cmd_flags.fail  = req_end_of_text && (fail_ff || !in_number || junk_ff);
      cmd_start       = start_ff;
      cmd_end         = (phase_ff == PH_NUM_A) ? start_ff : end_ff;
      cmd_step        = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         start_ff <= '0;
         end_ff   <= '0;
         step_ff  <= NUMBER_BITS'(1);
         junk_ff  <= 1'b0;
         fail_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         step_ff  <= step_in;
         junk_ff  <= junk_in;
         fail_ff  <= fail_in;
      end
   end

endmodule

/* hdl/cltm_fifo.sv */
`timescale 1ns / 1ps
// Small command queue in flip-flops between parser and walker.
// Depth must be a power of two. Depends on nothing.
module cltm_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hdl/cltm_walker.sv */
`timescale 1ns / 1ps
// Back end: pops commands, walks each range one CPU per cycle into the mask,
// and holds the result word until taken. Depends on cltm_pkg.
module cltm_walker #(
   parameter int unsigned CPU_COUNT   = 64,
   parameter int unsigned NUMBER_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_empty,
   input  cltm_pkg::cmd_flags_type          cmd_flags,
   input  logic [NUMBER_BITS-1:0]           cmd_start,
   input  logic [NUMBER_BITS-1:0]           cmd_end,
   input  logic [NUMBER_BITS-1:0]           cmd_step,
   output logic                             cmd_pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cltm_pkg::MASK_W-1:0]      rsp_cpu_mask,
   output logic                             rsp_valid_res
);
   import cltm_pkg::*;

   localparam int unsigned CW  = NUMBER_BITS + 1;
   localparam int unsigned CIW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

   walk_state_type          state_ff, state_in;
   logic [CW-1:0]           cpu_ff;
   logic [NUMBER_BITS-1:0]  end_ff;
   logic [NUMBER_BITS-1:0]  step_ff;
   logic                    last_ff;
   logic                    fail_ff;
   logic [CPU_COUNT-1:0]    mask_ff;

   logic                    bad_range, walk_go, take_rsp;
   logic [MASK_W-1:0]       mask_ext;

   assign bad_range = (cmd_step == '0) || (cmd_start > cmd_end);
   assign walk_go   = (cpu_ff <= CW'(end_ff)) && (cpu_ff < CW'(CPU_COUNT));
   assign take_rsp  = rsp_valid && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         WK_IDLE: begin
            if (!cmd_empty) begin
               priority if (cmd_flags.close && !bad_range) begin
                  state_in = WK_WALK;
               end else if (cmd_flags.last) begin
                  state_in = WK_SEND;
               end else begin
                  state_in = WK_IDLE;
               end
            end
         end
         WK_WALK: begin
            if (!walk_go) begin
               state_in = last_ff ? WK_SEND : WK_IDLE;
            end
         end
         WK_SEND: begin
            if (!rsp_stall) begin
               state_in = WK_IDLE;
            end
         end
         default: state_in = WK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop   = (state_ff == WK_IDLE) && !cmd_empty;
      rsp_valid = (state_ff == WK_SEND);
      mask_ext  = '0;
      mask_ext[CPU_COUNT-1:0] = mask_ff;
      rsp_cpu_mask  = fail_ff ? '0 : mask_ext;
      rsp_valid_res = !fail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WK_IDLE;
         fail_ff  <= 1'b0;
         mask_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (cmd_pop) begin
            fail_ff <= fail_ff || cmd_flags.fail || (cmd_flags.close && bad_range);
         end else if (take_rsp) begin
            fail_ff <= 1'b0;
         end
         if (state_ff == WK_WALK && walk_go) begin
            mask_ff[cpu_ff[CIW-1:0]] <= 1'b1;
         end else if (take_rsp) begin
            mask_ff <= '0;
         end
      end
   end

   // range walk registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cpu_ff  <= CW'(cmd_start);
         end_ff  <= cmd_end;
         step_ff <= cmd_step;
         last_ff <= cmd_flags.last;
      end else if (state_ff == WK_WALK && walk_go) begin
         cpu_ff <= cpu_ff + CW'(step_ff);
      end
   end

endmodule

/* hdl/cpu_list_text_to_mask_core.sv */
`timescale 1ns / 1ps
// Top level of the CPU list text to mask core: parser front, command queue,
// range walker back. Depends on cltm_pkg, cltm_front, cltm_fifo, cltm_walker.
//
//   channel   direction   handshake               word
//   req_      in          req_valid / req_stall   req_character, req_end_of_text
//   rsp_      out         rsp_valid / rsp_stall   rsp_cpu_mask, rsp_valid_res
//
// The front takes one text word per cycle while the queue has room; an
// end-of-text word, or a comma that closes a number, queues a command. The
// walker pops a command while idle; a token with a good range then visits
// every step-th CPU of its range below CPU_COUNT in turn and then finishes,
// and the queue hides that back-end time until it fills. An end word then
// offers the result until it is taken. Reset is synchronous and clears
// parser, queue and walker.
// req_stall rises only while the command queue is full; a finished result
// waits in the walker while the front keeps taking the next text.
module cpu_list_text_to_mask_core #(
   parameter int unsigned CPU_COUNT   = 64,
   parameter int unsigned NUMBER_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_character,
   input  logic                         req_end_of_text,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [cltm_pkg::MASK_W-1:0]  rsp_cpu_mask,
   output logic                         rsp_valid_res
);
   import cltm_pkg::*;

   // queue entry: flags, start, end, step
   localparam int unsigned QW = CMD_FLAGS_W + 3 * NUMBER_BITS;

   logic                    req_accept;
   logic                    front_push;
   cmd_flags_type           front_flags;
   logic [NUMBER_BITS-1:0]  front_start, front_end, front_step;

   logic [QW-1:0]           q_head;
   logic                    q_full, q_empty, q_pop;

   cmd_flags_type           head_flags;
   logic [NUMBER_BITS-1:0]  head_start, head_end, head_step;

   // hold the input only when the queue has no room
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   cltm_front #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (req_accept),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .cmd_push        (front_push),
      .cmd_flags       (front_flags),
      .cmd_start       (front_start),
      .cmd_end         (front_end),
      .cmd_step        (front_step)
   );

   cltm_fifo #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data ({front_flags, front_start, front_end, front_step}),
      .pop       (q_pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // unpack the queue head
   assign {head_flags, head_start, head_end, head_step} = q_head;

   cltm_walker #(
      .CPU_COUNT   (CPU_COUNT),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_walker (
      .clock         (clock),
      .reset         (reset),
      .cmd_empty     (q_empty),
      .cmd_flags     (head_flags),
      .cmd_start     (head_start),
      .cmd_end       (head_end),
      .cmd_step      (head_step),
      .cmd_pop       (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_cpu_mask  (rsp_cpu_mask),
      .rsp_valid_res (rsp_valid_res)
   );

   // the parser never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !q_full)
      else $error("command pushed into full queue");

   // the walker never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from empty queue");

   // a rejected text always reports an empty mask
   a_fail_mask_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_cpu_mask == '0))
      else $error("invalid result with nonzero mask");

   // a taken result is not offered again in the next cycle
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) |=> !rsp_valid)
      else $error("result repeated");

endmodule

/* tb/cltm_text_checker.sv */
`timescale 1ns / 1ps
// Checker for the CPU list text to mask core: watches both channels, predicts
// the mask of each text and compares every returned word. Depends on cltm_pkg.
module cltm_text_checker #(
   parameter int unsigned CPU_COUNT   = 64,
   parameter int unsigned NUMBER_BITS = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [7:0]                   req_character,
   input  logic                         req_end_of_text,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [cltm_pkg::MASK_W-1:0]  rsp_cpu_mask,
   input  logic                         rsp_valid_res,
   output int                           fail_count,
   output int                           pending_count
);
   import cltm_pkg::*;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              ok;
   } expected_word_type;

   expected_word_type      expected_sets[$];
   int                     mismatches = 0;

   phase_type              phase      = PH_START;
   logic [NUMBER_BITS-1:0] lo_cpu     = '0;
   logic [NUMBER_BITS-1:0] hi_cpu     = '0;
   logic [NUMBER_BITS-1:0] cpu_stride = NUMBER_BITS'(1);
   logic [MASK_W-1:0]      mask_acc   = '0;
   logic                   text_bad   = 1'b0;
   logic                   stray_seen = 1'b0;

   task automatic open_token();
      phase      = PH_START;
      lo_cpu     = '0;
      hi_cpu     = '0;
      cpu_stride = NUMBER_BITS'(1);
      stray_seen = 1'b0;
   endtask

   task automatic add_digit(inout logic [NUMBER_BITS-1:0] value, input logic [7:0] c);
      longint unsigned wide;
      wide = 64'(value) * 10 + 64'(c) - 64'(CHAR_ZERO);
      if (wide > (64'(1) << NUMBER_BITS) - 1) begin
         text_bad = 1'b1;
         wide     = 0;
      end
      value = NUMBER_BITS'(wide);
   endtask

   // Set every stride-th CPU of the token's range; CPUs past the mask drop out.
   task automatic close_range();
      if (cpu_stride == 0 || lo_cpu > hi_cpu) begin
         text_bad = 1'b1;
      end else begin
         for (longint unsigned cpu = 64'(lo_cpu);
              cpu <= 64'(hi_cpu) && cpu < CPU_COUNT; cpu += 64'(cpu_stride))
            mask_acc[cpu] = 1'b1;
      end
   endtask

   task automatic take_text_byte(input logic [7:0] c);
      logic digit;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (phase == PH_START || phase == PH_WANT_B || phase == PH_WANT_S) begin
         if (!digit) begin
            text_bad = 1'b1;
         end else if (phase == PH_START) begin
            lo_cpu = NUMBER_BITS'(c - CHAR_ZERO);
            phase  = PH_NUM_A;
         end else if (phase == PH_WANT_B) begin
            hi_cpu     = NUMBER_BITS'(c - CHAR_ZERO);
            stray_seen = 1'b0;
            phase      = PH_NUM_B;
         end else begin
            cpu_stride = NUMBER_BITS'(c - CHAR_ZERO);
            stray_seen = 1'b0;
            phase      = PH_NUM_S;
         end
      end else if (c == CHAR_COMMA) begin
         if (phase == PH_NUM_A) hi_cpu = lo_cpu;
         close_range();
         open_token();
      end else if (phase == PH_NUM_A) begin
         if (digit && !stray_seen) add_digit(lo_cpu, c);
         else if (c == CHAR_DASH) phase = PH_WANT_B;
         else stray_seen = 1'b1;
      end else if (phase == PH_NUM_B) begin
         if (digit && !stray_seen) add_digit(hi_cpu, c);
         else if (c == CHAR_COLON) phase = PH_WANT_S;
         else stray_seen = 1'b1;
      end else begin
         if (digit && !stray_seen) add_digit(cpu_stride, c);
         else stray_seen = 1'b1;
      end
   endtask

   task automatic finish_text();
      expected_word_type outcome;
      if (!text_bad) begin
         if (phase inside {PH_NUM_A, PH_NUM_B, PH_NUM_S}) begin
            if (stray_seen) text_bad = 1'b1;
            if (phase == PH_NUM_A) hi_cpu = lo_cpu;
            close_range();
         end else begin
            text_bad = 1'b1;
         end
      end
      outcome.ok   = !text_bad;
      outcome.mask = text_bad ? '0 : mask_acc;
      expected_sets.push_back(outcome);
      open_token();
      mask_acc = '0;
      text_bad = 1'b0;
   endtask

   always @(posedge clock) begin
      expected_word_type want;
      if (reset) begin
         open_token();
         mask_acc = '0;
         text_bad = 1'b0;
         expected_sets.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_sets.size() == 0) begin
               $error("result with none pending: rsp_cpu_mask %h rsp_valid_res %b",
                      rsp_cpu_mask, rsp_valid_res);
               mismatches++;
            end else begin
               want = expected_sets.pop_front();
               if (rsp_cpu_mask !== want.mask) begin
                  $error("rsp_cpu_mask: expected %h, actual %h", want.mask, rsp_cpu_mask);
                  mismatches++;
               end
               if (rsp_valid_res !== want.ok) begin
                  $error("rsp_valid_res: expected %b, actual %b", want.ok, rsp_valid_res);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_end_of_text) finish_text();
            else if (!text_bad) take_text_byte(req_character);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_sets.size();
   end

endmodule

/* tb/tb_cpu_list_text_to_mask_core.sv */
`timescale 1ns / 1ps
// Testbench top for the CPU list text to mask core: clock, reset, text
// stimulus and response stalls; checking lives in cltm_text_checker.
// Depends on cltm_pkg, cpu_list_text_to_mask_core and cltm_text_checker.
module tb_cpu_list_text_to_mask_core;
   import cltm_pkg::*;

   localparam int unsigned CPU_COUNT    = 64;
   localparam int unsigned NUMBER_BITS  = 20;
   localparam int          RANDOM_WORDS = 1350;
   // Back end drains at most a queue of full-range commas before going quiet.
   localparam int          DRAIN_CYCLES = 400;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [7:0]          req_character   = '0;
   logic                req_end_of_text = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [MASK_W-1:0]   rsp_cpu_mask;
   logic                rsp_valid_res;

   int                  fail_count;
   int                  pending_count;

   logic [7:0]          text_bytes[$];
   int                  words_sent = 0;
   int                  burst_left = 0;
   int                  stall_left = 0;
   int                  stall_mode = 0;

   cpu_list_text_to_mask_core #(
      .CPU_COUNT   (CPU_COUNT),
      .NUMBER_BITS (NUMBER_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cpu_mask    (rsp_cpu_mask),
      .rsp_valid_res   (rsp_valid_res)
   );

   cltm_text_checker #(
      .CPU_COUNT   (CPU_COUNT),
      .NUMBER_BITS (NUMBER_BITS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_character   (req_character),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cpu_mask    (rsp_cpu_mask),
      .rsp_valid_res   (rsp_valid_res),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial forever #2 clock = ~clock;

   // Hold reset at the start, then release it for good.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver stalls in phases of random length: open, sparse, dense, or solid.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = (stall_mode == 3) ? $urandom_range(1, 12) : $urandom_range(5, 60);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= 1'b1;
      endcase
   end

   // Drive one word and hold it until accepted. Between bursts, drop valid
   // for a random gap; some bursts come back to back with no gap at all.
   task automatic send_word(input logic [7:0] ch, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_valid       <= 1'b1;
      req_character   <= ch;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // Send the buffered text, then an end word with a random ignored byte.
   task automatic send_text();
      foreach (text_bytes[i]) send_word(text_bytes[i], 1'b0);
      send_word(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic load_text(input string s);
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endtask

   task automatic put_number(input int unsigned value);
      string digits;
      digits = $sformatf("%0d", value);
      if ($urandom_range(0, 9) == 0) text_bytes.push_back(CHAR_ZERO);
      for (int i = 0; i < digits.len(); i++) text_bytes.push_back(digits[i]);
   endtask

   // Mostly CPUs around the mask width, with the last CPU in the mask, the
   // first past it, the largest legal number and its overflow neighbor mixed in.
   function automatic int unsigned pick_cpu();
      case ($urandom_range(0, 9))
         6:       return $urandom_range(0, 9);
         7:       return $urandom_range(0, (1 << NUMBER_BITS) - 1);
         8:       return (1 << NUMBER_BITS) - 1 + $urandom_range(0, 1);
         9:       return 63 + $urandom_range(0, 1);
         default: return $urandom_range(0, 70);
      endcase
   endfunction

   function automatic int unsigned pick_stride();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return pick_cpu();
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   function automatic logic [7:0] pick_stray();
      case ($urandom_range(0, 4))
         0:       return 8'h00;
         1:       return 8'h20;
         2:       return 8'($urandom_range(0, 255));
         3:       return CHAR_COLON;
         default: return 8'h78;
      endcase
   endfunction

   // Build one text: mostly well-formed token lists with random content,
   // the rest broken tokens, stray bytes and raw noise.
   task automatic build_text();
      int          tokens;
      int          shape;
      int unsigned lo;
      text_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 10)) begin
            case ($urandom_range(0, 4))
               0:       text_bytes.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
               1:       text_bytes.push_back(CHAR_COMMA);
               2:       text_bytes.push_back(CHAR_DASH);
               3:       text_bytes.push_back(CHAR_COLON);
               default: text_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         tokens = $urandom_range(1, 4);
         for (int t = 0; t < tokens; t++) begin
            if (t > 0) text_bytes.push_back(CHAR_COMMA);
            // shape 0-6 single CPU, 7 colon with no range end, 8-12 range,
            // 13-16 range with stride, 17 dangling colon, 18 dangling dash,
            // 19 empty token
            shape = $urandom_range(0, 19);
            if (shape != 19) begin
               lo = pick_cpu();
               put_number(lo);
               if (shape == 7) begin
                  text_bytes.push_back(CHAR_COLON);
                  put_number(pick_stride());
               end else if (shape >= 8) begin
                  if ($urandom_range(0, 7) == 0) text_bytes.push_back(pick_stray());
                  text_bytes.push_back(CHAR_DASH);
                  if (shape != 18) begin
                     put_number(($urandom_range(0, 3) == 0) ? pick_cpu()
                                                            : lo + $urandom_range(0, 24));
                     if (shape >= 13) begin
                        text_bytes.push_back(CHAR_COLON);
                        if (shape != 17) put_number(pick_stride());
                     end
                  end
               end
               if ($urandom_range(0, 11) == 0) text_bytes.push_back(pick_stray());
            end
         end
      end
   endtask

   initial begin
      int random_start;
      wait (!reset);
      @(posedge clock);

      // Directed: a mixed list with range, stride, colon without range end,
      // stray bytes after a non-last number and a CPU past the mask.
      load_text("0-20:2,5:3,1a,70");
      send_text();
      // Empty text is an empty token.
      text_bytes.delete();
      send_text();
      // One past the largest legal number: overflow.
      load_text("1048576");
      send_text();
      // Byte zero is an ordinary stray byte between tokens.
      load_text("7");
      text_bytes.push_back(8'h00);
      text_bytes.push_back(CHAR_COMMA);
      text_bytes.push_back(8'hFF);
      send_text();

      // Random texts until the word budget is spent.
      random_start = words_sent;
      while (words_sent - random_start < RANDOM_WORDS) begin
         build_text();
         send_text();
      end
      req_valid <= 1'b0;

      // Let the checker see the last end word, wait out every result, then
      // give the core time to show any stray extra word.
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Hard stop, far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
